// ===== hw/rtl/multi_slot_sample_ring_buffer_core_defines.svh =====
// Assertion macros used by the ring buffer top level.
`ifndef MULTI_SLOT_SAMPLE_RING_BUFFER_CORE_DEFINES_SVH
`define MULTI_SLOT_SAMPLE_RING_BUFFER_CORE_DEFINES_SVH

// Same-cycle implication, checked on clk, off while in reset.
`define MSRB_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off while in reset.
`define MSRB_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/msrb_pkg.sv =====
// Shared types, codes and constants of the multi-slot sample ring buffer.
`default_nettype none

package msrb_pkg;

	// Default sizing
	localparam int SLOT_COUNT_DEF = 8;
	localparam int RING_DEPTH_DEF = 4096;

	// Field widths
	localparam int REQ_TYPE_W = 2;
	localparam int SLOT_IN_W  = 3;
	localparam int SAMPLE_W   = 32;
	localparam int OFFSET_W   = 12;
	localparam int POS_W      = 64;

	// Request codes
	localparam logic [REQ_TYPE_W-1:0] REQ_WRITE = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_POP   = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_PEEK  = 2'd2;

	// Controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_STAT
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;  // latch the request on its transfer
		logic exec;     // memory access and position update
		logic load;     // fill the result register
	} ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/msrb_req_if.sv =====
// Request channel: valid/ready handshake with the request fields.
`default_nettype none

interface msrb_req_if import msrb_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [SLOT_IN_W-1:0]  slot;
	logic [SAMPLE_W-1:0]   sample_in;
	logic [OFFSET_W-1:0]   peek_offset;

	modport source (output valid, req_type, slot, sample_in, peek_offset, input ready);
	modport sink (input valid, req_type, slot, sample_in, peek_offset, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/msrb_rsp_if.sv =====
// Result channel: valid/ready handshake with the result fields.
`default_nettype none

interface msrb_rsp_if import msrb_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_out;
	logic                sample_valid;
	logic [CNT_W-1:0]    avail_count;
	logic                has_data;

	modport source (output valid, sample_out, sample_valid, avail_count, has_data, input ready);
	modport sink (input valid, sample_out, sample_valid, avail_count, has_data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/msrb_ctrl.sv =====
// Controller state machine: request handshake, sequencing, result register valid.
`default_nettype none

module msrb_ctrl import msrb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q, state_next;
	logic        out_valid_q;
	logic        out_free;

	// Result register can take a new result when empty or being drained
	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_EXEC;
			end
			ST_EXEC: begin
				state_next = ST_STAT;
			end
			ST_STAT: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.exec    = 1'b0;
		cmd.load    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			ST_STAT: begin
				cmd.load = out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ===== hw/rtl/msrb_datapath.sv =====
// Datapath: per-slot positions, sample memory, status math and result register.
`default_nettype none

module msrb_datapath import msrb_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF,
	localparam int CNT_W = $clog2(RING_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctrl_cmd_t             cmd,
	input  logic [REQ_TYPE_W-1:0] req_type,
	input  logic [SLOT_IN_W-1:0]  slot,
	input  logic [SAMPLE_W-1:0]   sample_in,
	input  logic [OFFSET_W-1:0]   peek_offset,
	output logic [SAMPLE_W-1:0]   sample_out,
	output logic                  sample_valid,
	output logic [CNT_W-1:0]      avail_count,
	output logic                  has_data
);

	localparam int SLOT_W    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int IDX_W     = $clog2(RING_DEPTH);
	localparam int ADDR_W    = SLOT_W + IDX_W;
	localparam int MEM_DEPTH = SLOT_COUNT * (2 ** IDX_W);
	localparam int SUM_W     = ((IDX_W > OFFSET_W) ? IDX_W : OFFSET_W) + 1;
	localparam int CMP_W     = (CNT_W > OFFSET_W) ? CNT_W : OFFSET_W;

	// Latched request
	logic [REQ_TYPE_W-1:0] req_q;
	logic [SLOT_IN_W-1:0]  slot_q;
	logic [SAMPLE_W-1:0]   data_q;
	logic [OFFSET_W-1:0]   offset_q;

	// Per-slot state: free-running positions and their ring indexes
	logic [POS_W-1:0] wr_pos_q [SLOT_COUNT];
	logic [POS_W-1:0] rd_pos_q [SLOT_COUNT];
	logic [IDX_W-1:0] wr_idx_q [SLOT_COUNT];
	logic [IDX_W-1:0] rd_idx_q [SLOT_COUNT];

	logic [SAMPLE_W-1:0] mem [MEM_DEPTH];
	logic [SAMPLE_W-1:0] rd_data_q;
	logic                hit_q;

	logic [SAMPLE_W-1:0] sample_out_q;
	logic                sample_valid_q;
	logic [CNT_W-1:0]    avail_count_q;
	logic                has_data_q;

	logic              slot_ok;
	logic [SLOT_W-1:0] slot_idx;
	logic [POS_W-1:0]  diff;
	logic              nonzero;
	logic [CNT_W-1:0]  avail;
	logic [SUM_W-1:0]  peek_sum;
	logic [IDX_W-1:0]  peek_idx;
	logic              peek_ok;
	logic              do_write;
	logic              pop_hit;
	logic              peek_hit;
	logic              mem_re;
	logic [IDX_W-1:0]  ring_idx;
	logic [ADDR_W-1:0] mem_addr;
	logic [IDX_W-1:0]  wr_idx_next;
	logic [IDX_W-1:0]  rd_idx_next;

	// Request capture on transfer
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q    <= req_type;
			slot_q   <= slot;
			data_q   <= sample_in;
			offset_q <= peek_offset;
		end
	end

	assign slot_ok  = (32'(slot_q) < 32'(SLOT_COUNT));
	assign slot_idx = SLOT_W'(slot_q);

	// Slot status: unread count, clamp, peek window
	always_comb begin
		diff     = wr_pos_q[slot_idx] - rd_pos_q[slot_idx];
		nonzero  = (diff != '0);
		avail    = (diff > POS_W'(RING_DEPTH)) ? CNT_W'(RING_DEPTH) : diff[CNT_W-1:0];
		peek_sum = SUM_W'(rd_idx_q[slot_idx]) + SUM_W'(offset_q);
		peek_idx = (peek_sum >= SUM_W'(RING_DEPTH)) ?
			IDX_W'(peek_sum - SUM_W'(RING_DEPTH)) : IDX_W'(peek_sum);
		peek_ok  = (CMP_W'(offset_q) < CMP_W'(avail));
	end

	// Access decode
	assign do_write = cmd.exec && slot_ok && (req_q == REQ_WRITE);
	assign pop_hit  = cmd.exec && slot_ok && (req_q == REQ_POP) && nonzero;
	assign peek_hit = cmd.exec && slot_ok && (req_q == REQ_PEEK) && peek_ok;
	assign mem_re   = pop_hit || peek_hit;

	always_comb begin
		unique case (req_q)
			REQ_WRITE: ring_idx = wr_idx_q[slot_idx];
			REQ_POP:   ring_idx = rd_idx_q[slot_idx];
			default:   ring_idx = peek_idx;
		endcase
	end

	assign mem_addr = {slot_idx, ring_idx};

	// Ring index advance with wrap at the depth
	assign wr_idx_next = (wr_idx_q[slot_idx] == IDX_W'(RING_DEPTH - 1)) ?
		'0 : wr_idx_q[slot_idx] + 1'b1;
	assign rd_idx_next = (rd_idx_q[slot_idx] == IDX_W'(RING_DEPTH - 1)) ?
		'0 : rd_idx_q[slot_idx] + 1'b1;

	// Sample memory, registered read
	always_ff @(posedge clk) begin
		if (do_write) mem[mem_addr] <= data_q;
		if (mem_re) rd_data_q <= mem[mem_addr];
		if (cmd.exec) hit_q <= mem_re;
	end

	// Position update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				wr_pos_q[i] <= '0;
				rd_pos_q[i] <= '0;
				wr_idx_q[i] <= '0;
				rd_idx_q[i] <= '0;
			end
		end else begin
			if (do_write) begin
				wr_pos_q[slot_idx] <= wr_pos_q[slot_idx] + 1'b1;
				wr_idx_q[slot_idx] <= wr_idx_next;
			end
			if (pop_hit) begin
				rd_pos_q[slot_idx] <= rd_pos_q[slot_idx] + 1'b1;
				rd_idx_q[slot_idx] <= rd_idx_next;
			end
		end
	end

	// Result register, status taken after the update
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_out_q   <= hit_q ? rd_data_q : '0;
			sample_valid_q <= hit_q;
			avail_count_q  <= slot_ok ? avail : '0;
			has_data_q     <= slot_ok && nonzero;
		end
	end

	assign sample_out   = sample_out_q;
	assign sample_valid = sample_valid_q;
	assign avail_count  = avail_count_q;
	assign has_data     = has_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/multi_slot_sample_ring_buffer_core.sv =====
// Top level of the multi-slot sample ring buffer: controller plus datapath.
//
//  channel | dir | payload                                           | transfer
//  --------+-----+---------------------------------------------------+--------------------
//  req     | in  | req_type, slot, sample_in, peek_offset            | req.valid & ready
//  rsp     | out | sample_out, sample_valid, avail_count, has_data   | rsp.valid & ready
//
// An item goes through transfer, memory access with position update, and
// status and result load; the sample memory is single-port with registered
// read. One result per item, in order.
// The result register frees the input side: a new request is taken while a
// result waits, and its own result holds in the status step until rsp drains.
// Reset clears positions and control at once; the sample memory needs no clearing.
`default_nettype none

`include "multi_slot_sample_ring_buffer_core_defines.svh"

module multi_slot_sample_ring_buffer_core import msrb_pkg::*; #(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	msrb_req_if.sink   req,
	msrb_rsp_if.source rsp
);

	ctrl_cmd_t cmd;

	msrb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd)
	);

	msrb_datapath #(
		.SLOT_COUNT (SLOT_COUNT),
		.RING_DEPTH (RING_DEPTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.req_type     (req.req_type),
		.slot         (req.slot),
		.sample_in    (req.sample_in),
		.peek_offset  (req.peek_offset),
		.sample_out   (rsp.sample_out),
		.sample_valid (rsp.sample_valid),
		.avail_count  (rsp.avail_count),
		.has_data     (rsp.has_data)
	);

	// A result never overwrites one still waiting
	`MSRB_ASSERT_NOW(a_load_free, cmd.load, (!rsp.valid || rsp.ready), "result overwritten")
	// After a request transfer the block is busy
	`MSRB_ASSERT_NEXT(a_busy_after_req, cmd.capture, (!req.ready && cmd.exec), "request not executed")
	// Count and has-data flag agree
	`MSRB_ASSERT_NOW(a_count_flag, rsp.valid, (rsp.has_data == (rsp.avail_count != '0)), "count mismatch")

endmodule

`default_nettype wire

// ===== verif/tb_multi_slot_sample_ring_buffer_core.sv =====
// Self-checking testbench of the multi-slot sample ring buffer core.
`default_nettype none

module tb_multi_slot_sample_ring_buffer_core;
	import msrb_pkg::*;

	localparam int SLOT_COUNT     = SLOT_COUNT_DEF;
	localparam int RING_DEPTH     = RING_DEPTH_DEF;
	localparam int CNT_W          = $clog2(RING_DEPTH + 1);
	localparam int RANDOM_ITEMS   = 1650;
	localparam int DRAIN_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_REPORTS    = 10;
	localparam int IDLE_PCT       = 8;

	// Request code without a function in the block
	localparam logic [REQ_TYPE_W-1:0] REQ_UNUSED = 2'd3;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0] req_type;
		logic [SLOT_IN_W-1:0]  slot;
		logic [SAMPLE_W-1:0]   sample_in;
		logic [OFFSET_W-1:0]   peek_offset;
	} ring_req_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample_out;
		logic                sample_valid;
		logic [CNT_W-1:0]    avail_count;
		logic                has_data;
	} ring_rsp_t;

	logic clk;
	logic arst_n;

	msrb_req_if                            req_ch ();
	msrb_rsp_if #(.RING_DEPTH(RING_DEPTH)) rsp_ch ();

	multi_slot_sample_ring_buffer_core #(
		.SLOT_COUNT(SLOT_COUNT),
		.RING_DEPTH(RING_DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	// Shadow copy of the ring contents and positions
	logic [SAMPLE_W-1:0] ring_words [SLOT_COUNT*RING_DEPTH];
	logic [POS_W-1:0]    wr_ptr [SLOT_COUNT];
	logic [POS_W-1:0]    rd_ptr [SLOT_COUNT];

	ring_rsp_t awaited_results [$];

	int idle_pct      = IDLE_PCT;
	int rsp_hold_left = 0;
	int stall_cycles  = 0;
	int mismatches    = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int pops_hit      = 0;
	int pops_empty    = 0;
	int peeks_hit     = 0;
	int peeks_missed  = 0;

	// Clock and reset
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	function automatic logic [POS_W-1:0] clamped_avail(input int unsigned s);
		logic [POS_W-1:0] diff;
		diff = wr_ptr[s] - rd_ptr[s];
		return (diff > RING_DEPTH) ? POS_W'(RING_DEPTH) : diff;
	endfunction

	function automatic int unsigned ring_index(input int unsigned s, input logic [POS_W-1:0] pos);
		return s * RING_DEPTH + int'(pos % RING_DEPTH);
	endfunction

	// Applies one request to the shadow state and returns its result
	function automatic ring_rsp_t ring_access(input ring_req_t r);
		ring_rsp_t   o;
		int unsigned s;
		o = '0;
		s = 32'(r.slot);
		if (s >= SLOT_COUNT)
			return o;
		case (r.req_type)
			REQ_WRITE: begin
				ring_words[ring_index(s, wr_ptr[s])] = r.sample_in;
				wr_ptr[s] = wr_ptr[s] + 1'b1;
			end
			REQ_POP: begin
				if (wr_ptr[s] != rd_ptr[s]) begin
					o.sample_out   = ring_words[ring_index(s, rd_ptr[s])];
					o.sample_valid = 1'b1;
					rd_ptr[s]      = rd_ptr[s] + 1'b1;
				end
			end
			REQ_PEEK: begin
				if (POS_W'(r.peek_offset) < clamped_avail(s)) begin
					o.sample_out   = ring_words[ring_index(s, rd_ptr[s] + r.peek_offset)];
					o.sample_valid = 1'b1;
				end
			end
			default: ;
		endcase
		o.avail_count = CNT_W'(clamped_avail(s));
		o.has_data    = (wr_ptr[s] != rd_ptr[s]);
		return o;
	endfunction

	function automatic ring_req_t make_req(input logic [REQ_TYPE_W-1:0] kind,
			input int unsigned s, input logic [SAMPLE_W-1:0] word, input int unsigned off);
		ring_req_t r;
		r.req_type    = kind;
		r.slot        = s[SLOT_IN_W-1:0];
		r.sample_in   = word;
		r.peek_offset = off[OFFSET_W-1:0];
		return r;
	endfunction

	// Offers one request, waits for its transfer and queues the predicted result
	task automatic send_item(input ring_req_t item);
		ring_rsp_t want;
		if ($urandom_range(0, 99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= item.req_type;
		req_ch.slot        <= item.slot;
		req_ch.sample_in   <= item.sample_in;
		req_ch.peek_offset <= item.peek_offset;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		want = ring_access(item);
		awaited_results.push_back(want);
		items_sent++;
		if (item.req_type == REQ_POP) begin
			if (want.sample_valid) pops_hit++; else pops_empty++;
		end else if (item.req_type == REQ_PEEK) begin
			if (want.sample_valid) peeks_hit++; else peeks_missed++;
		end
	endtask

	// Stops offering and waits for every queued result
	task automatic wait_results_drained();
		req_ch.valid <= 1'b0;
		wait (awaited_results.size() == 0);
		@(posedge clk);
	endtask

	// Result sink: random stalls plus an optional long hold-off
	initial begin : result_sink
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_left > 0) begin
				rsp_hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	task automatic check_field(input string name, input logic [SAMPLE_W-1:0] want,
			input logic [SAMPLE_W-1:0] got);
		if (want !== got) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
					results_seen, name, want, got);
		end
	endtask

	// Result checker: each transfer against the oldest prediction
	always @(posedge clk) begin : result_check
		ring_rsp_t want;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (awaited_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("result transfer with no request pending: sample_out 0x%0h",
						rsp_ch.sample_out);
			end else begin
				want = awaited_results.pop_front();
				check_field("sample_out", want.sample_out, rsp_ch.sample_out);
				check_field("sample_valid", want.sample_valid, rsp_ch.sample_valid);
				check_field("avail_count", want.avail_count, rsp_ch.avail_count);
				check_field("has_data", want.has_data, rsp_ch.has_data);
			end
			results_seen++;
		end
	end

	// Watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", stall_cycles);
			$display("multi_slot_sample_ring_buffer_core regression: fail");
			$finish;
		end
	end

	// Empty pop, peek past data, unused code, word extremes, slot extremes
	task automatic test_directed();
		send_item(make_req(REQ_POP, 0, 32'h1234_5678, 0));
		send_item(make_req(REQ_PEEK, 0, 32'h0, 0));
		send_item(make_req(REQ_UNUSED, 0, 32'hFFFF_FFFF, 4095));
		send_item(make_req(REQ_WRITE, 0, 32'h0000_0000, 4095));
		send_item(make_req(REQ_WRITE, 0, 32'hFFFF_FFFF, 0));
		send_item(make_req(REQ_WRITE, 7, 32'hA5A5_5A5A, 0));
		send_item(make_req(REQ_PEEK, 0, 32'hFFFF_FFFF, 1));
		send_item(make_req(REQ_PEEK, 0, 32'h0, 2));
		send_item(make_req(REQ_PEEK, 0, 32'h0, 4095));
		send_item(make_req(REQ_UNUSED, 7, 32'h0, 0));
		send_item(make_req(REQ_POP, 0, 32'hFFFF_FFFF, 4095));
		send_item(make_req(REQ_POP, 0, 32'h0, 0));
		send_item(make_req(REQ_POP, 0, 32'h0, 0));
		send_item(make_req(REQ_PEEK, 7, 32'h0, 0));
		send_item(make_req(REQ_POP, 7, 32'h0, 0));
		send_item(make_req(REQ_POP, 7, 32'h0, 0));
		send_item(make_req(REQ_WRITE, 4, 32'h8000_0001, 2048));
		send_item(make_req(REQ_PEEK, 4, 32'h5555_AAAA, 0));
		send_item(make_req(REQ_UNUSED, 4, 32'h0, 0));
		wait_results_drained();
	endtask

	// Long receiver hold-off while requests are offered, then a full drain, then peeks
	task automatic test_backpressure();
		int unsigned s;
		rsp_hold_left = 400;
		repeat (48) begin
			s = $urandom_range(0, SLOT_COUNT - 1);
			if ($urandom_range(0, 1))
				send_item(make_req(REQ_WRITE, s, $urandom(), 0));
			else
				send_item(make_req(REQ_POP, s, 32'h0, 0));
		end
		wait_results_drained();
		repeat (16) send_item(make_req(REQ_PEEK, $urandom_range(0, SLOT_COUNT - 1), 32'h0,
			$urandom_range(0, 3)));
		wait_results_drained();
	endtask

	// Write bursts followed by reads on one slot, mixed with random noise
	task automatic test_random();
		int               start;
		int unsigned      s;
		int unsigned      burst;
		int unsigned      roll;
		logic [POS_W-1:0] avail;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			idle_pct = (items_sent - start >= 600 && items_sent - start < 1000) ? 0 : IDLE_PCT;
			s = $urandom_range(0, SLOT_COUNT - 1);
			if ($urandom_range(0, 99) < 80) begin
				burst = $urandom_range(1, 24);
				repeat (burst) send_item(make_req(REQ_WRITE, s, $urandom(), $urandom_range(0, 4095)));
				repeat ($urandom_range(1, burst + 2)) begin
					avail = clamped_avail(s);
					roll  = $urandom_range(0, 99);
					if (roll < 55)
						send_item(make_req(REQ_POP, s, $urandom(), $urandom_range(0, 4095)));
					else if (roll < 90 && avail != 0)
						send_item(make_req(REQ_PEEK, s, $urandom(),
							$urandom_range(0, int'(avail) - 1)));
					else
						send_item(make_req(REQ_PEEK, s, $urandom(), int'(avail)));
				end
			end else begin
				send_item(make_req(REQ_TYPE_W'($urandom_range(0, 3)), s, $urandom(),
					$urandom_range(0, 4095)));
			end
		end
		idle_pct = IDLE_PCT;
		wait_results_drained();
	endtask

	// Test sequence and final verdict
	initial begin : test_main
		req_ch.valid       <= 1'b0;
		req_ch.req_type    <= REQ_WRITE;
		req_ch.slot        <= '0;
		req_ch.sample_in   <= '0;
		req_ch.peek_offset <= '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			wr_ptr[i] = '0;
			rd_ptr[i] = '0;
		end
		wait (arst_n === 1'b1);
		@(posedge clk);

		test_directed();
		test_backpressure();
		test_random();

		wait (awaited_results.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			mismatches++;
			$display("%0d results never arrived", awaited_results.size());
		end

		$display("covered %0d request transfers and %0d results: %0d pops, %0d empty pops,",
			items_sent, results_seen, pops_hit, pops_empty);
		$display("%0d peeks, %0d peeks past data, %0d mismatches",
			peeks_hit, peeks_missed, mismatches);
		if (mismatches == 0)
			$display("multi_slot_sample_ring_buffer_core regression: pass");
		else
			$display("multi_slot_sample_ring_buffer_core regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
